[sv/assert_macros.svh]
// Assertion macros used by the checker file of the key debounce unit.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, quiet while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that holds during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/mkd_pkg.sv]
// Shared constants, types and helpers of the multi-key debounce unit.
// No dependencies; used by every module of the block by scoped name.
package mkd_pkg;

  // Default geometry
  localparam int NUM_KEYS_DEF     = 3;
  localparam int SAMPLE_DEPTH_DEF = 4;

  // Hold counter of key zero
  localparam int              HOLD_W             = 16;
  localparam logic [HOLD_W-1:0] HOLD_THRESHOLD_RST = 16'd1000;
  localparam logic [HOLD_W-1:0] HOLD_MAX           = 16'hFFFF;

  // Per-key status handed from a key lane to the top level
  typedef struct packed {
    logic all_low;   // history after this tick is all pressed
    logic all_high;  // history after this tick is all released
    logic stable;    // debounced level after this tick, 0 means pressed
    logic pressed;   // stable level fell on this tick
  } key_stat_t;

  // Round a bit count up to whole bytes
  function automatic int byte_pad(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

[sv/mkd_key.sv]
// One key lane: sample history shift register and debounced level.
// Depends on mkd_pkg for the key status struct.
module mkd_key #(
  parameter int SAMPLE_DEPTH = mkd_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               raw,
  output mkd_pkg::key_stat_t stat
);

  logic [SAMPLE_DEPTH-1:0] history;
  logic [SAMPLE_DEPTH-1:0] history_next;
  logic                    stable;
  logic                    stable_next;

  // Shift in the new sample and decide the debounced level
  always_comb begin
    history_next = {history[SAMPLE_DEPTH-2:0], raw};
    stat.all_low  = (history_next == '0);
    stat.all_high = &history_next;
    if (stat.all_low) begin
      stable_next = 1'b0;
    end else if (stat.all_high) begin
      stable_next = 1'b1;
    end else begin
      stable_next = stable;
    end
    stat.stable  = stable_next;
    stat.pressed = stable & ~stable_next;
  end

  // Advance the lane once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '1;
      stable  <= 1'b1;
    end else if (advance) begin
      history <= history_next;
      stable  <= stable_next;
    end
  end

endmodule

[sv/multi_key_debounce_long_press_unit.sv]
// A result word is registered; it is valid on the cycle after its scan word is taken.
// Throughput: one scan word per cycle; the single output register refills in
// the cycle it is drained, so only a stalled output holds back the input.
// Reset (rst, synchronous, active high): histories all released, levels
// released, hold count zero, hold threshold 1000, output register empty.
// Top level with key lanes, key-zero hold counter; uses mkd_pkg and mkd_key.
module multi_key_debounce_long_press_unit #(
  parameter int NUM_KEYS     = mkd_pkg::NUM_KEYS_DEF,
  parameter int SAMPLE_DEPTH = mkd_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  // scan words
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  input  logic [mkd_pkg::byte_pad(NUM_KEYS)-1:0]        s_tdata,  // raw_keys
  // result words
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // press_events, stable_levels, long_press
  output logic [mkd_pkg::byte_pad(2*NUM_KEYS+1)-1:0]    m_tdata,
  // hold threshold writes
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [mkd_pkg::HOLD_W-1:0]                    cfg_data
);

  localparam int OUT_W = mkd_pkg::byte_pad(2*NUM_KEYS+1);

  logic                          advance;
  logic [NUM_KEYS-1:0]           raw;
  mkd_pkg::key_stat_t            stat [NUM_KEYS];
  logic [mkd_pkg::HOLD_W-1:0]    hold_threshold;
  logic [mkd_pkg::HOLD_W-1:0]    thr_eff;
  logic [mkd_pkg::HOLD_W-1:0]    hold_count;
  logic [mkd_pkg::HOLD_W-1:0]    hold_upd;
  logic [mkd_pkg::HOLD_W-1:0]    hold_count_next;
  logic                          pulse;
  logic [OUT_W-1:0]              out_word_next;
  logic                          out_valid;
  logic [OUT_W-1:0]              out_word;

  assign advance   = s_tvalid & s_tready;
  assign s_tready  = ~out_valid | m_tready;
  assign cfg_ready = 1'b1;
  assign raw       = s_tdata[NUM_KEYS-1:0];

  // One debounce lane per key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    mkd_key #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_key (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .raw     (raw[k]),
      .stat    (stat[k])
    );
  end

  // Hold counter of key zero and long-press decision
  always_comb begin
    if (stat[0].all_low) begin
      hold_upd = (hold_count == mkd_pkg::HOLD_MAX) ? hold_count
                                                   : hold_count + 1'b1;
    end else if (stat[0].all_high) begin
      hold_upd = '0;
    end else begin
      hold_upd = hold_count;
    end
    thr_eff         = (hold_threshold == '0) ? {{(mkd_pkg::HOLD_W-1){1'b0}}, 1'b1}
                                             : hold_threshold;
    pulse           = (hold_upd >= thr_eff);
    hold_count_next = pulse ? '0 : hold_upd;
  end

  // Pack the result word
  always_comb begin
    out_word_next = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      out_word_next[k]            = stat[k].pressed;
      out_word_next[NUM_KEYS + k] = stat[k].stable;
    end
    out_word_next[2*NUM_KEYS] = pulse;
  end

  // Hold threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_threshold <= mkd_pkg::HOLD_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      hold_threshold <= cfg_data;
    end
  end

  // Advance the hold count with each scan word
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= '0;
    end else if (advance) begin
      hold_count <= hold_count_next;
    end
  end

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= out_word_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_word;

endmodule

[sv/mkd_checker.sv]
// Port-level checks of the multi-key debounce unit, bound to its top level.
// Depends on assert_macros.svh and mkd_pkg.
`include "assert_macros.svh"

module mkd_checker #(
  parameter int NUM_KEYS = mkd_pkg::NUM_KEYS_DEF
) (
  input logic                                       clk,
  input logic                                       rst,
  input logic                                       s_tvalid,
  input logic                                       s_tready,
  input logic                                       m_tvalid,
  input logic                                       m_tready,
  input logic [mkd_pkg::byte_pad(2*NUM_KEYS+1)-1:0] m_tdata
);

  logic [NUM_KEYS-1:0] events;
  logic [NUM_KEYS-1:0] levels;

  assign events = m_tdata[NUM_KEYS-1:0];
  assign levels = m_tdata[2*NUM_KEYS-1:NUM_KEYS];

  // A stalled result word stays put
  `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")

  // A press event only shows for a key whose debounced level is pressed
  `ASSERT_CLK(a_event_level, m_tvalid |-> (events & levels) == '0, "press event on a released key")

  // An empty output register never holds back the input
  `ASSERT_CLK(a_ready_empty, !m_tvalid |-> s_tready, "input stalled with empty output")

  // Every accepted scan word yields a result word on the next cycle
  `ASSERT_CLK(a_accept_result, s_tvalid && s_tready |=> m_tvalid, "accepted word gave no result")

endmodule

bind multi_key_debounce_long_press_unit mkd_checker #(.NUM_KEYS(NUM_KEYS)) u_mkd_checker (.*);
